FILE: sv/murmur3_32_byte_hasher_macros.svh
// assertion macros shared by the hasher checker
`ifndef MURMUR3_32_BYTE_HASHER_MACROS_SVH
`define MURMUR3_32_BYTE_HASHER_MACROS_SVH

// same-cycle implication, disabled during reset
`define M3H_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define M3H_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/m3h_pkg.sv
// shared constants, types and helpers of the murmur3 byte hasher
`default_nettype none

package m3h_pkg;

    localparam logic [31:0] C1         = 32'hcc9e2d51;
    localparam logic [31:0] C2         = 32'h1b873593;
    localparam logic [31:0] C_MIX_ADD  = 32'he6546b64;
    localparam logic [31:0] C_FMIX1    = 32'h85ebca6b;
    localparam logic [31:0] C_FMIX2    = 32'hc2b2ae35;
    localparam logic [31:0] C_FIVE     = 32'd5;
    localparam logic [31:0] SEED_RESET = 32'd42;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_C1,
        S_C2,
        S_MIX,
        S_ADD,
        S_FIN,
        S_F2,
        S_F3
    } t_state;

    // operand selection for the shared multiplier
    typedef enum logic [2:0] {
        MS_NONE,
        MS_C1,
        MS_C2,
        MS_K5,
        MS_FT,
        MS_FH,
        MS_F2
    } t_mul_sel;

    // control bundle from sequencer to datapath
    typedef struct packed {
        logic     in_ready;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     hash_add;
        logic     ld_out;
    } t_ctrl;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

endpackage

`default_nettype wire

FILE: sv/m3h_mul.sv
// shared 32x32 multiplier keeping the low word, registered result
`default_nettype none

module m3h_mul import m3h_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_p
);

    logic [31:0] w_low;
    logic [31:0] r_prod;

    // low word of the product, the high word is never needed
    assign w_low = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_low;
        end
    end

    assign o_p = r_prod;

endmodule

`default_nettype wire

FILE: sv/m3h_ctrl.sv
// sequencer that schedules block mixing and finalization on the multiplier
`default_nettype none

module m3h_ctrl import m3h_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_blk,
    input  wire logic i_last,
    input  wire logic i_out_free,
    output t_ctrl     o_ctrl
);

    t_state r_state, n_state;
    logic   r_blk, n_blk;
    logic   r_last, n_last;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    // state and item flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_blk   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_blk   <= n_blk;
            r_last  <= n_last;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_blk   = r_blk;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_blk  = i_blk;
                    n_last = i_last;
                    if (i_blk || i_last) begin
                        n_state = S_C1;
                    end
                end
            end
            S_C1:  n_state = S_C2;
            S_C2:  n_state = S_MIX;
            S_MIX: n_state = r_blk ? S_ADD : S_F2;
            S_ADD: n_state = r_last ? S_FIN : S_IDLE;
            S_FIN: n_state = S_F2;
            S_F2:  n_state = S_F3;
            S_F3: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.mul_sel  = MS_NONE;
        unique case (r_state)
            S_IDLE: o_ctrl.in_ready = 1'b1;
            S_C1: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MS_C1;
            end
            S_C2: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MS_C2;
            end
            S_MIX: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = r_blk ? MS_K5 : MS_FT;
            end
            S_ADD: o_ctrl.hash_add = 1'b1;
            S_FIN: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MS_FH;
            end
            S_F2: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MS_F2;
            end
            S_F3: o_ctrl.ld_out = i_out_free;
            default: o_ctrl.in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/murmur3_32_byte_hasher.sv
// top level of the murmur3 x86_32 byte hasher
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one message byte per beat
//   with i_data_byte, i_byte_valid and i_last. A beat with i_byte_valid low
//   carries no byte; with i_last high it still ends the message.
//   Output channel (o_out_valid / i_out_ready) delivers one o_hash beat per
//   message, from an output register.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the seed; always ready.
//   The seed loads into the running hash at once while no byte is counted.
// Steps (one shared 32x32 multiplier, registered, under a sequencer):
//   a byte that does not complete a block and is not last: packed, input stays ready
//   a byte that completes a block: two scramble multiplies,
//   the x5 multiply and the add
//   a last beat: the two scramble multiplies, then the fmix multiplies, with
//   the x5 multiply and the add between them if a block completes.
// Reset clears the sequencer and output valid, sets seed and hash to 42.
// If the receiver stalls, the finished hash waits in the final step and the
// input stays not ready until the output register is free.
`default_nettype none

module murmur3_32_byte_hasher import m3h_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [31:0] o_hash,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_seed
);

    t_ctrl       w_ctrl;
    logic        w_accept;
    logic        w_out_free;
    logic [1:0]  w_pos;
    logic        w_blk;
    logic [31:0] w_nb;
    logic [31:0] w_prod;
    logic [31:0] w_a, w_b;
    logic [31:0] w_t, w_fin;

    logic [31:0] r_seed;
    logic [31:0] r_hash;
    logic [31:0] r_pb;
    logic [31:0] r_count;
    logic [31:0] r_k;
    logic        r_out_valid;
    logic [31:0] r_out_hash;

    assign o_in_ready  = w_ctrl.in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_hash      = r_out_hash;

    assign w_accept   = i_in_valid && w_ctrl.in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // byte packing into the partial block
    assign w_pos = r_count[1:0];
    assign w_nb  = i_byte_valid ? (r_pb | ({24'd0, i_data_byte} << {w_pos, 3'b000})) : r_pb;
    assign w_blk = i_byte_valid && (w_pos == 2'd3);

    m3h_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_blk      (w_blk),
        .i_last     (i_last),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // multiplier operand selection
    always_comb begin
        w_a = 32'd0;
        w_b = 32'd0;
        w_t = 32'd0;
        case (w_ctrl.mul_sel)
            MS_C1: begin
                w_a = r_k;
                w_b = C1;
            end
            MS_C2: begin
                w_a = rotl32(w_prod, 15);
                w_b = C2;
            end
            MS_K5: begin
                w_a = rotl32(r_hash ^ w_prod, 13);
                w_b = C_FIVE;
            end
            MS_FT: begin
                w_t = r_hash ^ w_prod ^ r_count;
                w_a = w_t ^ (w_t >> 16);
                w_b = C_FMIX1;
            end
            MS_FH: begin
                w_t = r_hash ^ r_count;
                w_a = w_t ^ (w_t >> 16);
                w_b = C_FMIX1;
            end
            MS_F2: begin
                w_a = w_prod ^ (w_prod >> 13);
                w_b = C_FMIX2;
            end
            default: begin
                w_a = 32'd0;
                w_b = 32'd0;
            end
        endcase
    end

    m3h_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_ctrl.mul_en),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_prod)
    );

    assign w_fin = w_prod ^ (w_prod >> 16);

    // message state and seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= SEED_RESET;
            r_hash  <= SEED_RESET;
            r_pb    <= 32'd0;
            r_count <= 32'd0;
        end else begin
            if (w_accept) begin
                if (i_byte_valid) begin
                    r_count <= r_count + 32'd1;
                end
                r_pb <= w_blk ? 32'd0 : w_nb;
            end
            if (w_ctrl.hash_add) begin
                r_hash <= w_prod + C_MIX_ADD;
            end
            if (w_ctrl.ld_out) begin
                r_hash  <= r_seed;
                r_pb    <= 32'd0;
                r_count <= 32'd0;
            end
            if (i_cfg_valid) begin
                r_seed <= i_cfg_seed;
                if (r_count == 32'd0) begin
                    r_hash <= i_cfg_seed;
                end
            end
        end
    end

    // block word handed to the scramble
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_k <= w_nb;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.ld_out) begin
            r_out_hash <= w_fin;
        end
    end

endmodule

`default_nettype wire

FILE: sv/m3h_checker.sv
// port-level checker for the murmur3 byte hasher, bound to the top level
`default_nettype none
`include "murmur3_32_byte_hasher_macros.svh"

module m3h_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_byte_valid,
    input wire logic        i_last,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_hash,
    input wire logic        i_cfg_valid,
    input wire logic        o_cfg_ready
);

    logic w_acc;
    assign w_acc = i_in_valid && o_in_ready;

    // a stalled hash beat holds
    `M3H_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_hash), "stalled hash beat changed")

    // a last beat starts finalization, so the input goes not ready
    `M3H_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, w_acc && i_last, !o_in_ready, "input ready right after last beat")

    // an empty beat that is not last leaves the input ready
    `M3H_ASSERT_NEXT(a_empty_fast, i_clk, i_rst_n, w_acc && !i_byte_valid && !i_last, o_in_ready, "empty beat stalled the input")

    // the seed port never back-pressures
    `M3H_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready, "seed write not taken")

endmodule

bind murmur3_32_byte_hasher m3h_checker u_m3h_checker (.*);

`default_nettype wire
